### sv/coi_pkg.sv
// Shared constants and types for the costmap obstacle inflation block.
// Used by the top level and its port checker; no dependencies.
package coi_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;
    localparam int RADIUS_DEF     = 2;

    // Field widths
    localparam int COST_W     = 8;
    localparam int ENTRY_W    = COST_W + 1;
    localparam int DIM_W      = 11;
    localparam int TIDX_W     = 20;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    typedef logic [COST_W-1:0]    t_cost;
    typedef logic [ENTRY_W-1:0]   t_entry;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Obstacle marker
    localparam t_cost OBSTACLE_COST = 8'd254;

    // Input item kinds carried on tuser
    localparam logic FUNC_CELL = 1'b0;
    localparam logic FUNC_PAD  = 1'b1;

    // Configuration register indexes
    localparam t_cfg_idx REG_GRID_WIDTH    = 2'd0;
    localparam t_cfg_idx REG_GRID_HEIGHT   = 2'd1;
    localparam t_cfg_idx REG_TARGET_ENABLE = 2'd2;
    localparam t_cfg_idx REG_TARGET_INDEX  = 2'd3;

    // Configuration reset values
    localparam logic [DIM_W-1:0]  GRID_DIM_RESET     = 11'd1024;
    localparam logic [TIDX_W-1:0] TARGET_INDEX_RESET = 20'd0;

endpackage

### sv/coi_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module coi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [WIDTH-1:0] r_rdata;

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### sv/costmap_obstacle_inflation_top.sv
// Costmap obstacle inflation: streaming square dilation of obstacle cells.
// Depends on coi_pkg and coi_ram.
//
//  channel   | direction | handshake                    | payload
//  ----------+-----------+------------------------------+------------------------------
//  s_axis    | in        | s_axis_tvalid/s_axis_tready  | tdata: cell_cost, tuser: func
//  m_axis    | out       | m_axis_tvalid/m_axis_tready  | tdata: cost_out, tlast: last
//  cfg       | in        | i_cfg_valid/o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  One item per cycle sustained while s_axis_tready is high. An accepted cell is read
//  against the line store in the next cycle and its result (if any) passes through the
//  window stage into the output queue. The line store keeps 2*RADIUS rows in one RAM
//  word per column; the only loop is its read-modify-write, closed by a one-word bypass.
//  Reset is synchronous and needs no clearing pass: stale store and window entries
//  are masked at the grid borders. A three-entry output queue absorbs stalls;
//  s_axis_tready drops only when the queued results and the in-flight item fill the queue.
module costmap_obstacle_inflation_top #(
    parameter int MAX_WIDTH  = coi_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = coi_pkg::MAX_HEIGHT_DEF,
    parameter int RADIUS     = coi_pkg::RADIUS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // stream in
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    input  logic [coi_pkg::COST_W-1:0]      s_axis_tdata,   // [7:0] cell_cost
    input  logic [0:0]                      s_axis_tuser,   // [0] func
    // stream out
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [coi_pkg::COST_W-1:0]      m_axis_tdata,   // [7:0] cost_out
    output logic                            m_axis_tlast,
    // configuration writes
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [coi_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [coi_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int WIN    = 2 * RADIUS + 1;
    localparam int EW     = coi_pkg::ENTRY_W;
    localparam int CW     = coi_pkg::COST_W;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WEW    = $clog2(MAX_WIDTH + 1);
    localparam int HEW    = $clog2(MAX_HEIGHT + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 2 * RADIUS + 2);
    localparam int POS_W  = $clog2(MAX_WIDTH * MAX_HEIGHT + RADIUS * MAX_WIDTH + RADIUS + 1);
    localparam int TGT_W  = (POS_W > coi_pkg::TIDX_W) ? POS_W : coi_pkg::TIDX_W;
    localparam int CLW    = WEW + HEW + coi_pkg::DIM_W;
    localparam int WORD_W = RADIUS * (EW + 1);
    localparam int Q_DEPTH = 3;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [coi_pkg::DIM_W-1:0]  r_grid_width;
    logic [coi_pkg::DIM_W-1:0]  r_grid_height;
    logic                       r_target_enable;
    logic [coi_pkg::TIDX_W-1:0] r_target_index;

    logic [WEW-1:0]   w_eff;
    logic [HEW-1:0]   h_eff;
    logic [POS_W-1:0] delay;

    assign o_cfg_ready = 1'b1;

    // Clip the grid size to the supported range
    always_comb begin
        if (r_grid_width == '0) begin
            w_eff = WEW'(1);
        end else if (CLW'(r_grid_width) > CLW'(MAX_WIDTH)) begin
            w_eff = WEW'(MAX_WIDTH);
        end else begin
            w_eff = WEW'(r_grid_width);
        end
        if (r_grid_height == '0) begin
            h_eff = HEW'(1);
        end else if (CLW'(r_grid_height) > CLW'(MAX_HEIGHT)) begin
            h_eff = HEW'(MAX_HEIGHT);
        end else begin
            h_eff = HEW'(r_grid_height);
        end
    end

    // Distance from input position to the cell whose window just closed
    assign delay = POS_W'(w_eff) * POS_W'(RADIUS) + POS_W'(RADIUS);

    // ------------------------------------------------------------------
    // Input position and output position counters
    // ------------------------------------------------------------------
    logic [COL_W-1:0] r_in_col;
    logic [ROW_W-1:0] r_in_row;
    logic [POS_W-1:0] r_in_pos;
    logic [COL_W-1:0] r_out_col;
    logic [HEW-1:0]   r_out_row;

    logic             in_acc;
    logic             in_grid;
    logic             is_pad;
    logic             advance;
    logic             write_cell;
    logic             emit;
    logic             last;
    logic             is_target;
    logic [EW-1:0]    in_entry;
    logic [WEW-1:0]   in_col_p1;
    logic [WEW-1:0]   out_col_p1;
    logic [WIN-1:0]   row_ok;
    logic [WIN-1:0]   col_ok;

    assign in_acc     = s_axis_tvalid && s_axis_tready;
    assign in_grid    = CLW'(r_in_row) < CLW'(h_eff);
    assign is_pad     = (s_axis_tuser[0] == coi_pkg::FUNC_PAD);
    assign advance    = !(in_grid && is_pad);
    assign write_cell = in_grid && !is_pad;
    assign is_target  = r_target_enable && (TGT_W'(r_in_pos) == TGT_W'(r_target_index));
    assign emit       = advance && (r_in_pos >= delay);
    assign last       = (r_out_row == h_eff - HEW'(1)) &&
                        (WEW'(r_out_col) == w_eff - WEW'(1));
    assign in_col_p1  = WEW'(r_in_col) + WEW'(1);
    assign out_col_p1 = WEW'(r_out_col) + WEW'(1);

    // Build the stored entry: source flag over the cost
    always_comb begin
        in_entry = '0;
        if (write_cell) begin
            in_entry[CW-1:0] = s_axis_tdata;
            in_entry[CW]     = (s_axis_tdata == coi_pkg::OBSTACLE_COST) && !is_target;
        end
    end

    // Border masks for the window around the output cell
    always_comb begin
        for (int i = 0; i < WIN; i++) begin
            row_ok[i] = (int'(r_out_row) + RADIUS >= i) &&
                        (int'(r_out_row) + RADIUS - i <= int'(h_eff) - 1);
            col_ok[i] = (int'(r_out_col) + RADIUS >= i) &&
                        (int'(r_out_col) + RADIUS - i <= int'(w_eff) - 1);
        end
    end

    // Config writes, frame restart and counter advance
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width    <= coi_pkg::GRID_DIM_RESET;
            r_grid_height   <= coi_pkg::GRID_DIM_RESET;
            r_target_enable <= 1'b0;
            r_target_index  <= coi_pkg::TARGET_INDEX_RESET;
            r_in_col        <= '0;
            r_in_row        <= '0;
            r_in_pos        <= '0;
            r_out_col       <= '0;
            r_out_row       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                coi_pkg::REG_GRID_WIDTH: begin
                    r_grid_width <= i_cfg_data[coi_pkg::DIM_W-1:0];
                    r_in_col     <= '0;
                    r_in_row     <= '0;
                    r_in_pos     <= '0;
                    r_out_col    <= '0;
                    r_out_row    <= '0;
                end
                coi_pkg::REG_GRID_HEIGHT: begin
                    r_grid_height <= i_cfg_data[coi_pkg::DIM_W-1:0];
                    r_in_col      <= '0;
                    r_in_row      <= '0;
                    r_in_pos      <= '0;
                    r_out_col     <= '0;
                    r_out_row     <= '0;
                end
                coi_pkg::REG_TARGET_ENABLE: begin
                    r_target_enable <= i_cfg_data[0];
                end
                coi_pkg::REG_TARGET_INDEX: begin
                    r_target_index <= i_cfg_data[coi_pkg::TIDX_W-1:0];
                end
                default: begin
                end
            endcase
        end else if (in_acc && advance) begin
            if (emit && last) begin
                // final cell of the frame: start over
                r_in_col  <= '0;
                r_in_row  <= '0;
                r_in_pos  <= '0;
                r_out_col <= '0;
                r_out_row <= '0;
            end else begin
                r_in_pos <= r_in_pos + POS_W'(1);
                if (in_col_p1 >= w_eff) begin
                    r_in_col <= '0;
                    r_in_row <= r_in_row + ROW_W'(1);
                end else begin
                    r_in_col <= COL_W'(in_col_p1);
                end
                if (emit) begin
                    if (out_col_p1 >= w_eff) begin
                        r_out_col <= '0;
                        r_out_row <= r_out_row + HEW'(1);
                    end else begin
                        r_out_col <= COL_W'(out_col_p1);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input stage: item waiting for its line store word
    // ------------------------------------------------------------------
    logic              r_va;
    logic              r_a_emit;
    logic              r_a_last;
    logic [EW-1:0]     r_a_entry;
    logic [COL_W-1:0]  r_a_addr;
    logic [WIN-1:0]    r_a_row_ok;
    logic [WIN-1:0]    r_a_col_ok;
    logic              r_byp;
    logic [WORD_W-1:0] r_byp_word;

    logic [WORD_W-1:0] ram_rdata;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] wr_word;
    logic              load_a;

    assign load_a = in_acc && advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va     <= 1'b0;
            r_a_emit <= 1'b0;
        end else begin
            r_va     <= load_a;
            r_a_emit <= load_a && emit;
        end
    end

    // Hold the item payload; forward the word being written on a same-column hit
    always_ff @(posedge i_clk) begin
        if (load_a) begin
            r_a_last   <= last;
            r_a_entry  <= in_entry;
            r_a_addr   <= r_in_col;
            r_a_row_ok <= row_ok;
            r_a_col_ok <= col_ok;
            r_byp      <= r_va && (r_a_addr == r_in_col);
            r_byp_word <= wr_word;
        end
    end

    coi_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .i_clk   (i_clk),
        .i_we    (r_va),
        .i_waddr (r_a_addr),
        .i_wdata (wr_word),
        .i_re    (load_a),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Window stage: new column, store write-back, dilation
    // ------------------------------------------------------------------
    logic [WIN-1:0] new_col;
    logic [CW-1:0]  new_cost;
    logic [WIN-1:0] win_cols [0:WIN-1];
    logic [WIN-1:0] r_win [1:2*RADIUS];
    logic [CW-1:0]  r_cost_dly [1:RADIUS];
    logic           hit;
    logic [CW-1:0]  result;

    assign rd_word = r_byp ? r_byp_word : ram_rdata;

    // Unpack the column above the new cell and repack it one row deeper.
    // The nearest RADIUS slots keep the full entry, the rest only the source flag.
    always_comb begin
        new_col    = '0;
        wr_word    = '0;
        new_col[0] = r_a_entry[CW];
        for (int k = 1; k < WIN; k++) begin
            if (k - 1 < RADIUS) begin
                new_col[k] = rd_word[EW * (k - 1) + CW];
            end else begin
                new_col[k] = rd_word[EW * RADIUS + (k - 1 - RADIUS)];
            end
        end
        new_cost = rd_word[EW * (RADIUS - 1) +: CW];
        wr_word[0 +: EW] = r_a_entry;
        for (int k = 1; k < 2 * RADIUS; k++) begin
            if (k < RADIUS) begin
                wr_word[EW * k +: EW] = rd_word[EW * (k - 1) +: EW];
            end else if (k == RADIUS) begin
                wr_word[EW * RADIUS] = rd_word[EW * (RADIUS - 1) + CW];
            end else begin
                wr_word[EW * RADIUS + (k - RADIUS)] = rd_word[EW * RADIUS + (k - 1 - RADIUS)];
            end
        end
    end

    // OR the masked source flags of the window
    always_comb begin
        win_cols[0] = new_col;
        for (int a = 1; a < WIN; a++) begin
            win_cols[a] = r_win[a];
        end
        hit = 1'b0;
        for (int a = 0; a < WIN; a++) begin
            hit = hit | (|(win_cols[a] & r_a_row_ok & {WIN{r_a_col_ok[a]}}));
        end
        result = hit ? coi_pkg::OBSTACLE_COST : r_cost_dly[RADIUS];
    end

    // Advance the window and the center cost delay
    always_ff @(posedge i_clk) begin
        if (r_va) begin
            r_win[1]      <= new_col;
            r_cost_dly[1] <= new_cost;
            for (int a = 2; a <= 2 * RADIUS; a++) begin
                r_win[a] <= r_win[a - 1];
            end
            for (int a = 2; a <= RADIUS; a++) begin
                r_cost_dly[a] <= r_cost_dly[a - 1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic [CW:0] r_q [0:Q_DEPTH-1];
    logic [1:0]  r_wp;
    logic [1:0]  r_rp;
    logic [1:0]  r_cnt;
    logic        push;
    logic        pop;

    assign push          = r_va && r_a_emit;
    assign pop           = m_axis_tvalid && m_axis_tready;
    assign m_axis_tvalid = (r_cnt != 2'd0);
    assign m_axis_tdata  = r_q[r_rp][CW-1:0];
    assign m_axis_tlast  = r_q[r_rp][CW];
    assign s_axis_tready = (3'(r_cnt) + 3'(r_va)) < 3'(Q_DEPTH);

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= {r_a_last, result};
        end
    end

    // Track pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == 2'(Q_DEPTH - 1)) ? 2'd0 : r_wp + 2'd1;
            end
            if (pop) begin
                r_rp <= (r_rp == 2'(Q_DEPTH - 1)) ? 2'd0 : r_rp + 2'd1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

### sv/coi_checker.sv
// Port-level checks for the costmap obstacle inflation top level, and its bind.
// Depends on coi_pkg and costmap_obstacle_inflation_top.
module coi_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        s_axis_tvalid,
    input logic                        s_axis_tready,
    input logic                        m_axis_tvalid,
    input logic                        m_axis_tready,
    input logic [coi_pkg::COST_W-1:0]  m_axis_tdata,
    input logic                        m_axis_tlast
);

    // A stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A stalled result keeps its payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("result payload changed while stalled");

    // Input backpressure only comes from pending results
    a_bp_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // Input is taken again once the pending results have drained
    a_ready_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tready && !s_axis_tvalid ##1 !m_axis_tvalid |-> s_axis_tready)
        else $error("input not ready after output drained");

endmodule

bind costmap_obstacle_inflation_top coi_checker u_coi_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for costmap_obstacle_inflation_top: a directed table of
// stimulus, then random frames checked against an in-bench inflation predictor.
// Depends on coi_pkg and the RTL of the block.
module testbench;
    import coi_pkg::*;

    // Ring of past cells, deep enough to hold a full 5x5 window span
    localparam int RING_DEPTH    = (2 * RADIUS_DEF + 1) * MAX_WIDTH_DEF + 2 * RADIUS_DEF + 1;
    localparam int ITEM_GOAL     = 2000;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 10;
    localparam int QUIET_LIMIT   = 2000;
    localparam int MAX_REPORTS   = 40;

    typedef enum logic [1:0] {ROW_WRITE, ROW_CELL, ROW_PAD} row_kind_e;

    typedef struct packed {
        row_kind_e         kind;
        t_cfg_idx          reg_idx;
        logic [19:0]       value;      // register data, or the cell cost in [7:0]
        logic              typed;      // expected result given in the row
        t_cost             exp_cost;
        logic              exp_last;
    } dir_row_t;

    typedef struct packed {
        t_cost cost;
        logic  last;
    } inflated_t;

    typedef enum logic [1:0] {RX_OPEN, RX_THREE_OF_FOUR, RX_COIN, RX_BURSTY} rx_mode_e;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [COST_W-1:0]     s_axis_tdata = '0;
    logic [0:0]            s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [COST_W-1:0]     m_axis_tdata;
    logic                  m_axis_tlast;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // Expected result carried alongside a directed item
    logic                  row_typed = 1'b0;
    t_cost                 row_exp_cost = '0;
    logic                  row_exp_last = 1'b0;

    // Predictor state: configuration, input position, result count, cell ring
    logic [ENTRY_W-1:0]    ring_store [RING_DEPTH];
    logic [DIM_W-1:0]      grid_w_reg = GRID_DIM_RESET;
    logic [DIM_W-1:0]      grid_h_reg = GRID_DIM_RESET;
    logic                  target_en_reg = 1'b0;
    logic [TIDX_W-1:0]     target_idx_reg = TARGET_INDEX_RESET;
    int unsigned           in_col = 0;
    int unsigned           in_row = 0;
    int unsigned           out_count = 0;

    inflated_t             inflated_q [$];
    int                    fail_count = 0;
    int unsigned           quiet_cycles = 0;
    int unsigned           burst_left = 0;
    bit                    drained_once = 1'b0;
    int unsigned           rx_cycle = 0;
    rx_mode_e              rx_mode = RX_OPEN;

    // Directed part: clipped 1x1 grids, ignored padding, late cells, target
    dir_row_t directed_rows [26] = '{
        '{ROW_WRITE, REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_WRITE, REG_GRID_HEIGHT,   20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_WRITE, REG_TARGET_ENABLE, 20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_WRITE, REG_TARGET_INDEX,  20'd0,   1'b0, 8'd0,          1'b0},
        // padding before the grid is in: dropped
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_CELL,  REG_GRID_WIDTH,    20'd254, 1'b0, 8'd0,          1'b0},
        // cell after the grid is complete acts as padding
        '{ROW_CELL,  REG_GRID_WIDTH,    20'd17,  1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b1, OBSTACLE_COST, 1'b1},
        '{ROW_CELL,  REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b1, 8'd0,          1'b1},
        '{ROW_CELL,  REG_GRID_WIDTH,    20'd255, 1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b1, 8'd255,        1'b1},
        // target obstacle keeps its own cost
        '{ROW_WRITE, REG_TARGET_ENABLE, 20'd1,   1'b0, 8'd0,          1'b0},
        '{ROW_CELL,  REG_GRID_WIDTH,    20'd254, 1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b0, 8'd0,          1'b0},
        '{ROW_PAD,   REG_GRID_WIDTH,    20'd0,   1'b1, OBSTACLE_COST, 1'b1}
    };

    costmap_obstacle_inflation_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Clip a grid dimension to [1, top]
    function automatic int unsigned clip_dim(input logic [DIM_W-1:0] v, input int unsigned top);
        if (v == 0) return 1;
        if (v > top) return top;
        return v;
    endfunction

    // Take one accepted item; return 1 with the inflated cost of the next
    // cell when the window behind the input position is complete
    function automatic bit inflate_next(input logic func, input t_cost cost,
                                        output inflated_t res);
        int unsigned w, h, total, lag, p, q, r, c, r0, r1, c0, c1;
        logic [ENTRY_W-1:0] entry;
        bit hit;
        w = clip_dim(grid_w_reg, MAX_WIDTH_DEF);
        h = clip_dim(grid_h_reg, MAX_HEIGHT_DEF);
        total = w * h;
        lag = RADIUS_DEF * w + RADIUS_DEF;
        p = in_row * w + in_col;
        res = '0;
        // store the cell with its source flag; padding inside the grid is dropped
        if (p < total) begin
            if (func == FUNC_PAD) return 1'b0;
            entry = {1'b0, cost};
            if (cost == OBSTACLE_COST && !(target_en_reg && p == target_idx_reg))
                entry[COST_W] = 1'b1;
            ring_store[p % RING_DEPTH] = entry;
        end
        in_col++;
        if (in_col >= w) begin
            in_col = 0;
            in_row++;
        end
        if (p < lag) return 1'b0;
        // scan the window, clipped at all four borders
        q = out_count;
        r = q / w;
        c = q % w;
        r0 = (r >= RADIUS_DEF) ? r - RADIUS_DEF : 0;
        c0 = (c >= RADIUS_DEF) ? c - RADIUS_DEF : 0;
        r1 = r + RADIUS_DEF;
        c1 = c + RADIUS_DEF;
        if (r1 > h - 1) r1 = h - 1;
        if (c1 > w - 1) c1 = w - 1;
        hit = 1'b0;
        for (int unsigned rr = r0; rr <= r1; rr++)
            for (int unsigned cc = c0; cc <= c1; cc++)
                if (ring_store[(rr * w + cc) % RING_DEPTH][COST_W]) hit = 1'b1;
        res.cost = hit ? OBSTACLE_COST : ring_store[q % RING_DEPTH][COST_W-1:0];
        res.last = (q == total - 1);
        out_count++;
        if (out_count >= total) begin
            in_col = 0;
            in_row = 0;
            out_count = 0;
        end
        return 1'b1;
    endfunction

    // Drive one stream transaction; bursts and gaps are decided here
    task automatic send_item(input logic func, input t_cost cost, input logic typed,
                             input t_cost exp_cost, input logic exp_last);
        int unsigned gap;
        bit hold;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(64, 256)
                                                      : $urandom_range(1, 24);
            gap = $urandom_range(0, 6);
            hold = (!drained_once && inflated_q.size() != 0) || $urandom_range(0, 39) == 0;
            if (hold && gap == 0) gap = 1;
            if (gap != 0) s_axis_tvalid <= 1'b0;
            // hold off until every pending result is out
            if (hold) begin
                drained_once = 1'b1;
                while (inflated_q.size() != 0) @(posedge i_clk);
            end
            repeat (gap) @(posedge i_clk);
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= cost;
        row_typed     <= typed;
        row_exp_cost  <= exp_cost;
        row_exp_last  <= exp_last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Write one register once the block has gone idle
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (inflated_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Update the predictor on each transaction and check each result
    always @(posedge i_clk) begin : scoreboard
        inflated_t predicted;
        inflated_t oldest;
        bit produced;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_GRID_WIDTH: begin
                        grid_w_reg = i_cfg_data[DIM_W-1:0];
                        in_col = 0;
                        in_row = 0;
                        out_count = 0;
                    end
                    REG_GRID_HEIGHT: begin
                        grid_h_reg = i_cfg_data[DIM_W-1:0];
                        in_col = 0;
                        in_row = 0;
                        out_count = 0;
                    end
                    REG_TARGET_ENABLE: target_en_reg = i_cfg_data[0];
                    REG_TARGET_INDEX:  target_idx_reg = i_cfg_data[TIDX_W-1:0];
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready) begin
                produced = inflate_next(s_axis_tuser[0], s_axis_tdata, predicted);
                if (row_typed)
                    inflated_q.push_back(inflated_t'({row_exp_cost, row_exp_last}));
                else if (produced)
                    inflated_q.push_back(predicted);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (inflated_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display("%0t: result with none pending: expected nothing, got cost %0d last %0b",
                                 $time, m_axis_tdata, m_axis_tlast);
                end else begin
                    oldest = inflated_q.pop_front();
                    if (m_axis_tdata !== oldest.cost) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: cost_out expected %0d, got %0d",
                                     $time, oldest.cost, m_axis_tdata);
                    end
                    if (m_axis_tlast !== oldest.last) begin
                        fail_count++;
                        if (fail_count <= MAX_REPORTS)
                            $display("%0t: last expected %0b, got %0b",
                                     $time, oldest.last, m_axis_tlast);
                    end
                end
            end
        end
    end

    // Receiver stall pattern in one of four modes, redrawn at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            rx_cycle <= rx_cycle + 1;
            if (rx_cycle % 256 == 255) rx_mode <= rx_mode_e'($urandom_range(0, 3));
            case (rx_mode)
                RX_OPEN:          m_axis_tready <= 1'b1;
                RX_THREE_OF_FOUR: m_axis_tready <= (rx_cycle % 4) != 3;
                RX_COIN:          m_axis_tready <= 1'($urandom_range(0, 1));
                default:          m_axis_tready <= (rx_cycle % 24) >= 16;
            endcase
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned ph, fr, nframes, eff_w, eff_h, total, len, cut, pos, tidx, items_sent;
        logic [DIM_W-1:0] w_val, h_val;
        t_cost cost;
        bit restart;
        w_val = '0;
        h_val = '0;
        items_sent = 0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table
        foreach (directed_rows[i]) begin
            if (directed_rows[i].kind == ROW_WRITE)
                write_reg(directed_rows[i].reg_idx, directed_rows[i].value);
            else
                send_item((directed_rows[i].kind == ROW_PAD) ? FUNC_PAD : FUNC_CELL,
                          directed_rows[i].value[COST_W-1:0], directed_rows[i].typed,
                          directed_rows[i].exp_cost, directed_rows[i].exp_last);
        end

        // Random phases: new settings, then frames with random content
        ph = 0;
        while (ph < 6 || items_sent < ITEM_GOAL) begin
            restart = (ph == 0 || ph == 2 || ph == 5 || $urandom_range(0, 3) != 0);
            if (restart) begin
                case (ph)
                    2: begin
                        w_val = 11'd1024;
                        h_val = 11'd1;
                    end
                    5: begin
                        w_val = 11'd1;
                        h_val = 11'd2047;
                    end
                    default: begin
                        w_val = ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 16));
                        h_val = ($urandom_range(0, 15) == 0) ? 11'd0 : 11'($urandom_range(1, 8));
                    end
                endcase
                write_reg(REG_GRID_WIDTH, {9'($urandom), w_val});
                write_reg(REG_GRID_HEIGHT, {9'($urandom), h_val});
            end
            eff_w = clip_dim(w_val, MAX_WIDTH_DEF);
            eff_h = clip_dim(h_val, MAX_HEIGHT_DEF);
            total = eff_w * eff_h;
            tidx = ($urandom_range(0, 7) == 0) ? 32'hFFFFF : $urandom_range(0, total - 1);
            write_reg(REG_TARGET_ENABLE, {19'($urandom), 1'($urandom_range(0, 1))});
            write_reg(REG_TARGET_INDEX, 20'(tidx));

            nframes = (total > 64) ? 1 : $urandom_range(1, 3);
            for (fr = 0; fr < nframes; fr++) begin
                len = total + RADIUS_DEF * eff_w + RADIUS_DEF;
                // now and then cut the last frame short; the next size write restarts it
                cut = (fr == nframes - 1 && total <= 64 && $urandom_range(0, 4) == 0)
                      ? $urandom_range(1, len - 1) : len;
                for (pos = 0; pos < cut; pos++) begin
                    if (pos < total) begin
                        if ($urandom_range(0, 15) == 0)
                            send_item(FUNC_PAD, t_cost'($urandom), 1'b0, '0, 1'b0);
                        if (pos == tidx && $urandom_range(0, 1) == 1)
                            cost = OBSTACLE_COST;
                        else if ($urandom_range(0, 5) == 0)
                            cost = OBSTACLE_COST;
                        else
                            cost = t_cost'($urandom_range(0, 255));
                        send_item(FUNC_CELL, cost, 1'b0, '0, 1'b0);
                    end else begin
                        send_item(1'($urandom_range(0, 1)), t_cost'($urandom), 1'b0, '0, 1'b0);
                    end
                    items_sent++;
                end
            end
            ph++;
        end

        // Drain and report
        s_axis_tvalid <= 1'b0;
        while (inflated_q.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
